>>> sv/hhd_pkg.sv
// shared types and constants for the hci h4 uart deframer
package hhd_pkg;

  localparam logic [7:0] IND_ACL   = 8'h02;
  localparam logic [7:0] IND_EVENT = 8'h04;
  localparam logic [7:0] IND_SLEEP = 8'h30;

  // header bytes after the indicator: event code + length, acl handle(2) + length(2)
  localparam logic [1:0] EVT_HDR_FIRST = 2'd0;
  localparam logic [1:0] ACL_LEN_LO    = 2'd2;
  localparam logic [1:0] ACL_HDR_LAST  = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_EVENT = 2'd1,
    KIND_ACL   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] packet_kind;
    logic       packet_start;
    logic       in_header;
    logic       packet_end;
    logic       bad_indicator;
    logic       sleep_request;
  } result_t;

endpackage

>>> sv/hhd_in_stage.sv
// input register for received bytes
module hhd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       byte_valid,
  output logic [7:0] byte_q,
  input  logic       take
);

  logic       valid;
  logic [7:0] data;

  assign in_ready   = !valid || take;
  assign byte_valid = valid;
  assign byte_q     = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= rx_byte;
    end
  end

endmodule

>>> sv/hhd_parser.sv
// packet framing state and per-byte tagging
module hhd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       d,
  output hhd_pkg::result_t res
);

  hhd_pkg::phase_t phase, phase_next;
  hhd_pkg::kind_t  kind, kind_next;
  logic [1:0]      header_count, header_count_next;
  logic [7:0]      length_low, length_low_next;
  logic [15:0]     remaining, remaining_next;

  logic            kind_ok;
  logic [15:0]     acl_len;

  assign kind_ok = (kind == hhd_pkg::KIND_EVENT) || (kind == hhd_pkg::KIND_ACL);
  assign acl_len = {d, length_low};

  // next state
  always_comb begin
    phase_next        = phase;
    kind_next         = kind;
    header_count_next = header_count;
    length_low_next   = length_low;
    remaining_next    = remaining;
    priority if (phase == hhd_pkg::PH_HEADER && kind_ok) begin
      if (kind == hhd_pkg::KIND_EVENT) begin
        if (header_count == hhd_pkg::EVT_HDR_FIRST) begin
          header_count_next = 2'd1;
        end else if (d == 8'd0) begin
          phase_next        = hhd_pkg::PH_IDLE;
          kind_next         = hhd_pkg::KIND_NONE;
          header_count_next = 2'd0;
          length_low_next   = 8'd0;
          remaining_next    = 16'd0;
        end else begin
          remaining_next = {8'd0, d};
          phase_next     = hhd_pkg::PH_PAYLOAD;
        end
      end else begin
        if (header_count != hhd_pkg::ACL_HDR_LAST) begin
          if (header_count == hhd_pkg::ACL_LEN_LO) begin
            length_low_next = d;
          end
          header_count_next = header_count + 2'd1;
        end else if (acl_len == 16'd0) begin
          phase_next        = hhd_pkg::PH_IDLE;
          kind_next         = hhd_pkg::KIND_NONE;
          header_count_next = 2'd0;
          length_low_next   = 8'd0;
          remaining_next    = 16'd0;
        end else begin
          remaining_next = acl_len;
          phase_next     = hhd_pkg::PH_PAYLOAD;
        end
      end
    end else if (phase == hhd_pkg::PH_PAYLOAD && kind_ok) begin
      if (remaining <= 16'd1) begin
        phase_next        = hhd_pkg::PH_IDLE;
        kind_next         = hhd_pkg::KIND_NONE;
        header_count_next = 2'd0;
        length_low_next   = 8'd0;
        remaining_next    = 16'd0;
      end else begin
        remaining_next = remaining - 16'd1;
      end
    end else begin
      phase_next        = hhd_pkg::PH_IDLE;
      kind_next         = hhd_pkg::KIND_NONE;
      header_count_next = 2'd0;
      length_low_next   = 8'd0;
      remaining_next    = 16'd0;
      if (d == hhd_pkg::IND_EVENT) begin
        kind_next  = hhd_pkg::KIND_EVENT;
        phase_next = hhd_pkg::PH_HEADER;
      end else if (d == hhd_pkg::IND_ACL) begin
        kind_next  = hhd_pkg::KIND_ACL;
        phase_next = hhd_pkg::PH_HEADER;
      end
    end
  end

  // item tags
  always_comb begin
    res               = '0;
    res.data_byte     = d;
    priority if (phase == hhd_pkg::PH_HEADER && kind_ok) begin
      res.packet_kind = kind;
      res.in_header   = 1'b1;
      if (kind == hhd_pkg::KIND_EVENT) begin
        res.packet_end = (header_count != hhd_pkg::EVT_HDR_FIRST) && (d == 8'd0);
      end else begin
        res.packet_end = (header_count == hhd_pkg::ACL_HDR_LAST) && (acl_len == 16'd0);
      end
    end else if (phase == hhd_pkg::PH_PAYLOAD && kind_ok) begin
      res.packet_kind = kind;
      res.packet_end  = (remaining <= 16'd1);
    end else begin
      if (d == hhd_pkg::IND_EVENT) begin
        res.packet_kind  = hhd_pkg::KIND_EVENT;
        res.packet_start = 1'b1;
        res.in_header    = 1'b1;
      end else if (d == hhd_pkg::IND_ACL) begin
        res.packet_kind  = hhd_pkg::KIND_ACL;
        res.packet_start = 1'b1;
        res.in_header    = 1'b1;
      end else if (d == hhd_pkg::IND_SLEEP) begin
        res.sleep_request = 1'b1;
      end else begin
        res.bad_indicator = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hhd_pkg::PH_IDLE;
      kind         <= hhd_pkg::KIND_NONE;
      header_count <= 2'd0;
      length_low   <= 8'd0;
      remaining    <= 16'd0;
    end else if (step) begin
      phase        <= phase_next;
      kind         <= kind_next;
      header_count <= header_count_next;
      length_low   <= length_low_next;
      remaining    <= remaining_next;
    end
  end

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == hhd_pkg::PH_PAYLOAD |-> remaining != 16'd0)
    else $error("payload phase with zero remaining count");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == hhd_pkg::PH_IDLE |-> kind == hhd_pkg::KIND_NONE && remaining == 16'd0)
    else $error("idle phase with stale packet state");

  a_open_kind: assert property (@(posedge clk) disable iff (rst)
    phase != hhd_pkg::PH_IDLE |-> kind == hhd_pkg::KIND_EVENT || kind == hhd_pkg::KIND_ACL)
    else $error("open packet without a valid kind");

  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    step && res.packet_start |=> phase == hhd_pkg::PH_HEADER && header_count == 2'd0)
    else $error("indicator did not open header phase");

endmodule

>>> sv/hhd_out_stage.sv
// result register toward the receiver
module hhd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  output logic             res_ready,
  input  hhd_pkg::result_t res,
  output logic             out_valid,
  input  logic             out_ready,
  output hhd_pkg::result_t res_q
);

  logic             valid;
  hhd_pkg::result_t data;

  assign res_ready = !valid || out_ready;
  assign out_valid = valid;
  assign res_q     = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_ready) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data <= res;
    end
  end

endmodule

>>> sv/hci_uart_h4_deframer_top.sv
// top level of the hci h4 uart deframer
// Splits a received UART byte stream into HCI H4 event and ACL packets.
// Input channel: one received byte per item on rx_byte, with in_valid/in_ready.
// Output channel: one tagged item per input byte, with out_valid/out_ready:
//   data_byte echoes the byte, packet_kind gives 0 none, 1 event, 2 acl,
//   packet_start/in_header/packet_end mark the framing, bad_indicator flags
//   a dropped unsupported indicator, sleep_request flags the sleep indicator.
// A byte accepted into the input register is tagged combinationally and its result
// is captured in the result register, from which the receiver takes it.
// Throughput: one byte per cycle while the receiver does not stall, set by the framing
// state update between the input register and the result register.
// Reset (rst, synchronous) empties both registers and returns the framer to
// waiting for an indicator.
// When the receiver holds out_ready low, the result register keeps its item,
// the input register fills with one more byte, and in_ready then drops until
// the receiver takes the waiting result.
module hci_uart_h4_deframer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic [1:0] packet_kind,
  output logic       packet_start,
  output logic       in_header,
  output logic       packet_end,
  output logic       bad_indicator,
  output logic       sleep_request
);

  logic             byte_valid;
  logic [7:0]       byte_q;
  logic             res_ready;
  logic             step;
  hhd_pkg::result_t res;
  hhd_pkg::result_t res_q;

  assign step = byte_valid && res_ready;

  hhd_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .byte_valid(byte_valid),
    .byte_q    (byte_q),
    .take      (step)
  );

  hhd_parser u_parser (
    .clk (clk),
    .rst (rst),
    .step(step),
    .d   (byte_q),
    .res (res)
  );

  hhd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .res_valid(byte_valid),
    .res_ready(res_ready),
    .res      (res),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res_q    (res_q)
  );

  assign data_byte     = res_q.data_byte;
  assign packet_kind   = res_q.packet_kind;
  assign packet_start  = res_q.packet_start;
  assign in_header     = res_q.in_header;
  assign packet_end    = res_q.packet_end;
  assign bad_indicator = res_q.bad_indicator;
  assign sleep_request = res_q.sleep_request;

endmodule

>>> tb/sv/hhd_frame_checker.sv
// frame predictor and result checker for the hci h4 uart deframer
module hhd_frame_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] data_byte,
  input  logic [1:0] packet_kind,
  input  logic       packet_start,
  input  logic       in_header,
  input  logic       packet_end,
  input  logic       bad_indicator,
  input  logic       sleep_request,
  output int         errors,
  output int         results_due
);

  hhd_pkg::phase_t ph;
  hhd_pkg::kind_t  kd;
  logic [1:0]      hdr_cnt;
  logic [7:0]      len_lo;
  logic [15:0]     left;

  hhd_pkg::result_t frames_due[$];
  hhd_pkg::result_t want;
  int               fails = 0;
  int               due_count = 0;

  assign errors      = fails;
  assign results_due = due_count;

  function void frame_idle();
    ph      = hhd_pkg::PH_IDLE;
    kd      = hhd_pkg::KIND_NONE;
    hdr_cnt = '0;
    len_lo  = '0;
    left    = '0;
  endfunction

  function automatic hhd_pkg::result_t frame_step(input logic [7:0] b);
    hhd_pkg::result_t r;
    logic [15:0]      len;
    r = '0;
    r.data_byte = b;
    if (ph == hhd_pkg::PH_HEADER &&
        (kd == hhd_pkg::KIND_EVENT || kd == hhd_pkg::KIND_ACL)) begin
      r.packet_kind = kd;
      r.in_header   = 1'b1;
      if (kd == hhd_pkg::KIND_EVENT) begin
        if (hdr_cnt == hhd_pkg::EVT_HDR_FIRST) begin
          hdr_cnt = hdr_cnt + 2'd1;
        end else if (b == 8'h00) begin
          r.packet_end = 1'b1;
          frame_idle();
        end else begin
          left = {8'h00, b};
          ph   = hhd_pkg::PH_PAYLOAD;
        end
      end else begin
        if (hdr_cnt != hhd_pkg::ACL_HDR_LAST) begin
          if (hdr_cnt == hhd_pkg::ACL_LEN_LO) len_lo = b;
          hdr_cnt = hdr_cnt + 2'd1;
        end else begin
          len = {b, len_lo};
          if (len == 16'h0000) begin
            r.packet_end = 1'b1;
            frame_idle();
          end else begin
            left = len;
            ph   = hhd_pkg::PH_PAYLOAD;
          end
        end
      end
    end else if (ph == hhd_pkg::PH_PAYLOAD &&
                 (kd == hhd_pkg::KIND_EVENT || kd == hhd_pkg::KIND_ACL)) begin
      r.packet_kind = kd;
      if (left <= 16'd1) begin
        r.packet_end = 1'b1;
        frame_idle();
      end else begin
        left = left - 16'd1;
      end
    end else begin
      frame_idle();
      if (b == hhd_pkg::IND_EVENT || b == hhd_pkg::IND_ACL) begin
        kd = (b == hhd_pkg::IND_EVENT) ? hhd_pkg::KIND_EVENT : hhd_pkg::KIND_ACL;
        ph = hhd_pkg::PH_HEADER;
        r.packet_kind  = kd;
        r.packet_start = 1'b1;
        r.in_header    = 1'b1;
      end else if (b == hhd_pkg::IND_SLEEP) begin
        r.sleep_request = 1'b1;
      end else begin
        r.bad_indicator = 1'b1;
      end
    end
    return r;
  endfunction

  task report(input string msg);
    fails++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task check_field(input string name, input logic [7:0] got, input logic [7:0] exp_val);
    if (got !== exp_val)
      report($sformatf("%s got %0h want %0h (byte %0h)", name, got, exp_val,
                       want.data_byte));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frames_due.delete();
      frame_idle();
      due_count <= 0;
    end else begin
      if (in_valid && in_ready) frames_due.push_back(frame_step(rx_byte));
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          report($sformatf("result %0h with no byte waiting", data_byte));
        end else begin
          want = frames_due.pop_front();
          check_field("data_byte", data_byte, want.data_byte);
          check_field("packet_kind", {6'd0, packet_kind}, {6'd0, want.packet_kind});
          check_field("packet_start", {7'd0, packet_start}, {7'd0, want.packet_start});
          check_field("in_header", {7'd0, in_header}, {7'd0, want.in_header});
          check_field("packet_end", {7'd0, packet_end}, {7'd0, want.packet_end});
          check_field("bad_indicator", {7'd0, bad_indicator}, {7'd0, want.bad_indicator});
          check_field("sleep_request", {7'd0, sleep_request}, {7'd0, want.sleep_request});
        end
      end
      due_count <= frames_due.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
// stimulus, receiver stalls and verdict for the hci h4 uart deframer
module testbench;

  localparam int IDLE_LIMIT = 2000;
  localparam int BYTE_GOAL  = 400;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] data_byte;
  logic [1:0] packet_kind;
  logic       packet_start;
  logic       in_header;
  logic       packet_end;
  logic       bad_indicator;
  logic       sleep_request;
  int         errors;
  int         results_due;

  int         burst_left = 1;
  bit         valid_up = 0;
  int         framed_bytes = 0;
  bit         big_sent = 0;
  int         idle_cycles = 0;
  int         stall_cyc = 0;
  int         stall_mode = 0;
  int         sel;

  always #2 clk = ~clk;

  hci_uart_h4_deframer_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .data_byte(data_byte), .packet_kind(packet_kind), .packet_start(packet_start),
    .in_header(in_header), .packet_end(packet_end),
    .bad_indicator(bad_indicator), .sleep_request(sleep_request)
  );

  hhd_frame_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .data_byte(data_byte), .packet_kind(packet_kind), .packet_start(packet_start),
    .in_header(in_header), .packet_end(packet_end),
    .bad_indicator(bad_indicator), .sleep_request(sleep_request),
    .errors(errors), .results_due(results_due)
  );

  // receiver stalls: out_ready follows one of four patterns, redrawn at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      stall_cyc++;
      if (stall_cyc % 200 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= (stall_cyc % 5 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    int gap;
    rx_byte  <= b;
    in_valid <= 1'b1;
    valid_up = 1;
    do @(posedge clk); while (!in_ready);
    framed_bytes++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_up = 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 0;
    end
    do @(posedge clk); while (results_due != 0);
  endtask

  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = hhd_pkg::IND_ACL;
      1: b = hhd_pkg::IND_EVENT;
      2: b = hhd_pkg::IND_SLEEP;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  task automatic send_event(input int len);
    put_byte(hhd_pkg::IND_EVENT);
    put_byte(8'($urandom_range(0, 255)));
    put_byte(len[7:0]);
    for (int i = 0; i < len; i++) put_byte(payload_byte());
  endtask

  task automatic send_acl(input int len);
    put_byte(hhd_pkg::IND_ACL);
    put_byte(8'($urandom_range(0, 255)));
    put_byte(8'($urandom_range(0, 255)));
    put_byte(len[7:0]);
    put_byte(len[15:8]);
    for (int i = 0; i < len; i++) put_byte(payload_byte());
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    rx_byte  = 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero-length event, end on the length byte
    put_byte(hhd_pkg::IND_EVENT); put_byte(8'h0e); put_byte(8'h00);
    put_byte(hhd_pkg::IND_EVENT); put_byte(8'hff); put_byte(8'h01); put_byte(8'hff);
    // zero-length acl, end on the high length byte
    put_byte(hhd_pkg::IND_ACL); put_byte(8'h00); put_byte(8'h00);
    put_byte(8'h00); put_byte(8'h00);
    put_byte(hhd_pkg::IND_ACL); put_byte(8'hff); put_byte(8'hff);
    put_byte(8'h02); put_byte(8'h00);
    put_byte(8'haa); put_byte(8'h55);
    // sleep, then command, sync and unknown indicators
    put_byte(hhd_pkg::IND_SLEEP); put_byte(8'h01); put_byte(8'h03);
    put_byte(8'h00); put_byte(8'hff);
    drain();

    while (framed_bytes < BYTE_GOAL) begin
      sel = $urandom_range(0, 99);
      if (!big_sent && framed_bytes >= 60) begin
        // length with a nonzero high byte
        send_acl(16'h0104);
        big_sent = 1;
      end else if (sel < 45) begin
        send_event(($urandom_range(0, 9) == 0) ? $urandom_range(0, 32)
                                               : $urandom_range(0, 8));
      end else if (sel < 80) begin
        send_acl(($urandom_range(0, 9) == 0) ? $urandom_range(0, 48)
                                             : $urandom_range(0, 8));
      end else if (sel < 88) begin
        put_byte(hhd_pkg::IND_SLEEP);
      end else begin
        put_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 49) == 0) drain();
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
